[src/touch_gesture_recognizer_assert.svh]
// Assertion macros used by the checker of the touch gesture recognizer.
`ifndef TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TGR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch gesture recognizer check failed");

// Next-cycle implication, disabled while reset is high.
`define TGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch gesture recognizer check failed");

`endif

[src/tgr_pkg.sv]
// ----------------------------------------------------------------------------
// tgr_pkg
// Types, codes and constants shared by the touch gesture recognizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

   localparam int SLOTS_DEFAULT = 5;
   // Finger counts go up to the table size; this width holds sizes up to 31.
   localparam int COUNT_W       = 5;
   localparam int MAX_RESULTS   = 3;
   localparam int RES_IDX_W     = 2;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   // Event kinds.
   localparam logic [1:0] OP_DOWN   = 2'd0;
   localparam logic [1:0] OP_UP     = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   // Result actions.
   localparam logic [2:0] ACT_LEFT_DOWN  = 3'd0;
   localparam logic [2:0] ACT_LEFT_UP    = 3'd1;
   localparam logic [2:0] ACT_RIGHT_DOWN = 3'd2;
   localparam logic [2:0] ACT_RIGHT_UP   = 3'd3;
   localparam logic [2:0] ACT_KEY_PRESS  = 3'd4;
   localparam logic [2:0] ACT_CALIBRATE  = 3'd5;
   localparam logic [2:0] ACT_HOLD_CLICK = 3'd6;
   localparam logic [2:0] ACT_MOVE       = 3'd7;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_TWO_FINGER_KEY   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_THREE_FINGER_KEY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FOUR_FINGER_KEY  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FIVE_FINGER_KEY  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_KEY         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_TIME_MS     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MOVE_LIMIT       = 3'd6;

   // Special key codes.
   localparam logic [7:0] KEY_NONE         = 8'd0;
   localparam logic [7:0] KEY_RIGHT_BUTTON = 8'd2;
   localparam logic [7:0] KEY_CALIBRATE    = 8'd252;

   // Register reset values.
   localparam logic [7:0]  RST_TWO_FINGER_KEY   = 8'd2;
   localparam logic [7:0]  RST_THREE_FINGER_KEY = 8'd27;
   localparam logic [7:0]  RST_FOUR_FINGER_KEY  = 8'd0;
   localparam logic [7:0]  RST_FIVE_FINGER_KEY  = 8'd0;
   localparam logic [7:0]  RST_HOLD_KEY         = 8'd18;
   localparam logic [15:0] RST_HOLD_TIME_MS     = 16'd500;
   localparam logic [7:0]  RST_MOVE_LIMIT       = 8'd4;

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         key_code;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
   } result_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic emit_next;
   } cmd_type;

   typedef struct packed {
      logic no_result;
      logic last;
   } sts_type;

   function automatic result_type make_result(input logic [2:0] action,
                                              input logic [7:0] key_code,
                                              input logic signed [15:0] out_x,
                                              input logic signed [15:0] out_y);
      result_type r;
      r.action   = action;
      r.key_code = key_code;
      r.out_x    = out_x;
      r.out_y    = out_y;
      return r;
   endfunction

endpackage

`default_nettype wire

[src/tgr_datapath.sv]
// ----------------------------------------------------------------------------
// tgr_datapath
// Event registers, pointer slot table, button owners, hold timer, settings
// registers and the small result buffer that feeds the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_datapath
   import tgr_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   input  wire logic [1:0]             req_operation,
   input  wire logic [15:0]            req_pointer_id,
   input  wire logic signed [15:0]     req_pos_x,
   input  wire logic signed [15:0]     req_pos_y,
   input  wire logic                   req_stylus_button,
   input  wire logic                   req_primary,
   input  wire logic [31:0]            req_time_ms,
   input  wire logic                   req_suspended,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic [2:0]                  rsp_action,
   output logic [7:0]                  rsp_key_code,
   output logic signed [15:0]          rsp_out_x,
   output logic signed [15:0]          rsp_out_y,
   output logic                        rsp_last
);

   localparam int SLOT_IW = $clog2(SLOTS);

   // Captured event.
   logic [1:0]         op_ff;
   logic [15:0]        id_ff;
   logic signed [15:0] x_ff;
   logic signed [15:0] y_ff;
   logic               stylus_ff;
   logic               primary_ff;
   logic [31:0]        time_ff;
   logic               susp_ff;

   // Settings.
   logic [7:0]  two_key_ff;
   logic [7:0]  three_key_ff;
   logic [7:0]  four_key_ff;
   logic [7:0]  five_key_ff;
   logic [7:0]  hold_key_ff;
   logic [15:0] hold_time_ff;
   logic [7:0]  move_limit_ff;

   // Tracking state.
   logic [15:0] slot_ff [SLOTS];
   logic [15:0] slot_in [SLOTS];
   logic [15:0] left_owner_ff, left_owner_in;
   logic [15:0] right_owner_ff, right_owner_in;
   logic        hold_armed_ff, hold_armed_in;
   logic [31:0] hold_start_ff, hold_start_in;
   logic [15:0] hold_x_ff, hold_x_in;
   logic [15:0] hold_y_ff, hold_y_in;

   // Result buffer.
   result_type           res_ff [MAX_RESULTS];
   result_type           res_in [MAX_RESULTS];
   logic [RES_IDX_W-1:0] res_cnt_ff, res_cnt_in;
   logic [RES_IDX_W-1:0] emit_idx_ff;

   // Table search.
   logic               free_found;
   logic [SLOT_IW-1:0] free_idx;
   logic               match_found;
   logic [SLOT_IW-1:0] match_idx;
   logic [COUNT_W-1:0] finger_count;

   logic [31:0] elapsed;
   logic        hold_fire;
   logic [16:0] dx, dy, adx, ady;
   logic        moved;
   logic        left_match, right_match;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_operation;
         id_ff      <= req_pointer_id;
         x_ff       <= req_pos_x;
         y_ff       <= req_pos_y;
         stylus_ff  <= req_stylus_button;
         primary_ff <= req_primary;
         time_ff    <= req_time_ms;
         susp_ff    <= req_suspended;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         two_key_ff    <= RST_TWO_FINGER_KEY;
         three_key_ff  <= RST_THREE_FINGER_KEY;
         four_key_ff   <= RST_FOUR_FINGER_KEY;
         five_key_ff   <= RST_FIVE_FINGER_KEY;
         hold_key_ff   <= RST_HOLD_KEY;
         hold_time_ff  <= RST_HOLD_TIME_MS;
         move_limit_ff <= RST_MOVE_LIMIT;
      end else if (csr_write) begin
         case (csr_index)
            REG_TWO_FINGER_KEY:   two_key_ff    <= csr_data[7:0];
            REG_THREE_FINGER_KEY: three_key_ff  <= csr_data[7:0];
            REG_FOUR_FINGER_KEY:  four_key_ff   <= csr_data[7:0];
            REG_FIVE_FINGER_KEY:  five_key_ff   <= csr_data[7:0];
            REG_HOLD_KEY:         hold_key_ff   <= csr_data[7:0];
            REG_HOLD_TIME_MS:     hold_time_ff  <= csr_data[15:0];
            REG_MOVE_LIMIT:       move_limit_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // First free slot and first slot holding this pointer.
   always_comb begin
      free_found  = 1'b0;
      free_idx    = '0;
      match_found = 1'b0;
      match_idx   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!free_found && slot_ff[i] == 16'd0) begin
            free_found = 1'b1;
            free_idx   = SLOT_IW'(i);
         end
         if (!match_found && slot_ff[i] == id_ff) begin
            match_found = 1'b1;
            match_idx   = SLOT_IW'(i);
         end
      end
   end

   // A full table counts as SLOTS fingers.
   assign finger_count = stylus_ff  ? COUNT_W'(2) :
                         free_found ? COUNT_W'(free_idx) + COUNT_W'(1) :
                                      COUNT_W'(SLOTS);

   assign elapsed   = time_ff - hold_start_ff;
   assign hold_fire = hold_armed_ff && (elapsed > {16'd0, hold_time_ff});

   assign dx    = {x_ff[15], x_ff} - {hold_x_ff[15], hold_x_ff};
   assign dy    = {y_ff[15], y_ff} - {hold_y_ff[15], hold_y_ff};
   assign adx   = dx[16] ? (17'd0 - dx) : dx;
   assign ady   = dy[16] ? (17'd0 - dy) : dy;
   assign moved = (adx > {9'd0, move_limit_ff}) || (ady > {9'd0, move_limit_ff});

   assign left_match  = (left_owner_ff != 16'd0) && (left_owner_ff == id_ff);
   assign right_match = (right_owner_ff != 16'd0) && (right_owner_ff == id_ff);

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      for (int r = 0; r < MAX_RESULTS; r++) begin
         res_in[r] = '0;
      end
      res_cnt_in     = '0;
      left_owner_in  = left_owner_ff;
      right_owner_in = right_owner_ff;
      hold_armed_in  = hold_armed_ff;
      hold_start_in  = hold_start_ff;
      hold_x_in      = hold_x_ff;
      hold_y_in      = hold_y_ff;

      case (op_ff)
         OP_DOWN: begin
            if (!susp_ff) begin
               if (free_found) begin
                  slot_in[free_idx] = id_ff;
               end
               case (finger_count)
                  COUNT_W'(1): begin
                     res_in[res_cnt_in] = make_result(ACT_LEFT_DOWN, KEY_NONE, x_ff, y_ff);
                     res_cnt_in         = res_cnt_in + 1'b1;
                     left_owner_in      = id_ff;
                     if (hold_key_ff != KEY_NONE) begin
                        hold_armed_in = 1'b1;
                        hold_start_in = time_ff;
                        hold_x_in     = x_ff;
                        hold_y_in     = y_ff;
                     end
                  end
                  COUNT_W'(2): begin
                     if (two_key_ff == KEY_RIGHT_BUTTON) begin
                        res_in[res_cnt_in] = make_result(ACT_RIGHT_DOWN, KEY_NONE, '0, '0);
                        right_owner_in     = id_ff;
                     end else begin
                        res_in[res_cnt_in] = make_result(ACT_KEY_PRESS, two_key_ff, '0, '0);
                     end
                     res_cnt_in = res_cnt_in + 1'b1;
                  end
                  COUNT_W'(3): begin
                     if (three_key_ff != KEY_NONE) begin
                        res_in[res_cnt_in] = make_result(ACT_KEY_PRESS, three_key_ff, '0, '0);
                        res_cnt_in         = res_cnt_in + 1'b1;
                     end
                  end
                  COUNT_W'(4): begin
                     if (four_key_ff != KEY_NONE) begin
                        res_in[res_cnt_in] = make_result(ACT_KEY_PRESS, four_key_ff, '0, '0);
                        res_cnt_in         = res_cnt_in + 1'b1;
                     end
                  end
                  COUNT_W'(5): begin
                     if (five_key_ff == KEY_CALIBRATE) begin
                        res_in[res_cnt_in] = make_result(ACT_CALIBRATE, KEY_NONE, '0, '0);
                        res_cnt_in         = res_cnt_in + 1'b1;
                     end else if (five_key_ff != KEY_NONE) begin
                        res_in[res_cnt_in] = make_result(ACT_KEY_PRESS, five_key_ff, '0, '0);
                        res_cnt_in         = res_cnt_in + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         OP_UP: begin
            if (match_found) begin
               slot_in[match_idx] = 16'd0;
            end
            if (left_match) begin
               res_in[res_cnt_in] = make_result(ACT_LEFT_UP, KEY_NONE, '0, '0);
               res_cnt_in         = res_cnt_in + 1'b1;
               left_owner_in      = 16'd0;
               if (hold_fire) begin
                  res_in[res_cnt_in] = make_result(ACT_HOLD_CLICK, hold_key_ff, '0, '0);
                  res_cnt_in         = res_cnt_in + 1'b1;
               end
               hold_armed_in = 1'b0;
            end
            if (right_match) begin
               res_in[res_cnt_in] = make_result(ACT_RIGHT_UP, KEY_NONE, '0, '0);
               res_cnt_in         = res_cnt_in + 1'b1;
               right_owner_in     = 16'd0;
            end
         end
         OP_UPDATE: begin
            if (!susp_ff) begin
               if (primary_ff) begin
                  res_in[res_cnt_in] = make_result(ACT_MOVE, KEY_NONE, x_ff, y_ff);
                  res_cnt_in         = res_cnt_in + 1'b1;
               end
               // Moving too far restarts the hold timer from the new position.
               if (left_match && hold_armed_ff && moved) begin
                  hold_start_in = time_ff;
                  hold_x_in     = x_ff;
                  hold_y_in     = y_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_ff[i] <= 16'd0;
         end
         left_owner_ff  <= 16'd0;
         right_owner_ff <= 16'd0;
         hold_armed_ff  <= 1'b0;
         hold_start_ff  <= 32'd0;
         hold_x_ff      <= 16'd0;
         hold_y_ff      <= 16'd0;
         res_cnt_ff     <= '0;
         emit_idx_ff    <= '0;
      end else if (cmd.eval) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
         left_owner_ff  <= left_owner_in;
         right_owner_ff <= right_owner_in;
         hold_armed_ff  <= hold_armed_in;
         hold_start_ff  <= hold_start_in;
         hold_x_ff      <= hold_x_in;
         hold_y_ff      <= hold_y_in;
         res_cnt_ff     <= res_cnt_in;
         emit_idx_ff    <= '0;
      end else if (cmd.emit_next && !sts.last) begin
         emit_idx_ff <= emit_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         for (int r = 0; r < MAX_RESULTS; r++) begin
            res_ff[r] <= res_in[r];
         end
      end
   end

   assign sts.no_result = (res_cnt_in == '0);
   assign sts.last      = (emit_idx_ff == res_cnt_ff - 1'b1);

   assign rsp_action   = res_ff[emit_idx_ff].action;
   assign rsp_key_code = res_ff[emit_idx_ff].key_code;
   assign rsp_out_x    = res_ff[emit_idx_ff].out_x;
   assign rsp_out_y    = res_ff[emit_idx_ff].out_y;
   assign rsp_last     = sts.last;

endmodule

`default_nettype wire

[src/tgr_ctrl.sv]
// ----------------------------------------------------------------------------
// tgr_ctrl
// Sequencer: takes one event, evaluates it, then hands out its results.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_ctrl
   import tgr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.eval      = 1'b0;
      cmd.emit_next = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.no_result ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cmd.emit_next = 1'b1;
               if (sts.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/touch_gesture_recognizer.sv]
// ----------------------------------------------------------------------------
// touch_gesture_recognizer
// Turns pointer down, up and update events into mouse and key actions.
// ----------------------------------------------------------------------------
// One event is handled at a time: it is taken, then evaluated in the next
// cycle against the pointer slot table, the button owners and the hold
// timer, and its results, none to three of them, then leave one per cycle
// from a small buffer while rsp_stall is low, the final one flagged by
// rsp_last. The controller steps each event through take, evaluate and
// emit. Settings are written through the csr port, which is always ready.
`default_nettype none

module touch_gesture_recognizer
   import tgr_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_operation,
   input  wire logic [15:0]            req_pointer_id,
   input  wire logic signed [15:0]     req_pos_x,
   input  wire logic signed [15:0]     req_pos_y,
   input  wire logic                   req_stylus_button,
   input  wire logic                   req_primary,
   input  wire logic [31:0]            req_time_ms,
   input  wire logic                   req_suspended,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [2:0]                  rsp_action,
   output logic [7:0]                  rsp_key_code,
   output logic signed [15:0]          rsp_out_x,
   output logic signed [15:0]          rsp_out_y,
   output logic                        rsp_last,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   tgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   tgr_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_pointer_id    (req_pointer_id),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_stylus_button (req_stylus_button),
      .req_primary       (req_primary),
      .req_time_ms       (req_time_ms),
      .req_suspended     (req_suspended),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_action        (rsp_action),
      .rsp_key_code      (rsp_key_code),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

[src/tgr_checker.sv]
// ----------------------------------------------------------------------------
// tgr_checker
// Port-level checks of the touch gesture recognizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_gesture_recognizer_assert.svh"

module tgr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_action,
   input wire logic [7:0]  rsp_key_code,
   input wire logic [15:0] rsp_out_x,
   input wire logic [15:0] rsp_out_y,
   input wire logic        rsp_last
);

   // A stalled result holds its payload.
   `TGR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_action) && $stable(rsp_key_code) && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_last))

   // No new event is taken while results of the previous one are pending.
   `TGR_ASSERT_IMP(a_one_event, clock, reset, rsp_valid, req_stall)

   // The cycle after an event transfer is spent evaluating it.
   `TGR_ASSERT_NEXT(a_eval_gap, clock, reset, req_valid && !req_stall, !rsp_valid && req_stall)

   // A result transfer that is not flagged last is followed by another result.
   `TGR_ASSERT_NEXT(a_more_follow, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid)

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_action   (rsp_action),
   .rsp_key_code (rsp_key_code),
   .rsp_out_x    (rsp_out_x),
   .rsp_out_y    (rsp_out_y),
   .rsp_last     (rsp_last)
);

`default_nettype wire

[tb/touch_gesture_checker.sv]
// ----------------------------------------------------------------------------
// touch_gesture_checker
// Watches the event, result and register channels of the touch gesture
// recognizer, predicts the actions of every accepted event and compares each
// result transfer against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module touch_gesture_checker
   import tgr_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [1:0]             req_operation,
   input  wire logic [15:0]            req_pointer_id,
   input  wire logic signed [15:0]     req_pos_x,
   input  wire logic signed [15:0]     req_pos_y,
   input  wire logic                   req_stylus_button,
   input  wire logic                   req_primary,
   input  wire logic [31:0]            req_time_ms,
   input  wire logic                   req_suspended,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [2:0]             rsp_action,
   input  wire logic [7:0]             rsp_key_code,
   input  wire logic signed [15:0]     rsp_out_x,
   input  wire logic signed [15:0]     rsp_out_y,
   input  wire logic                   rsp_last,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          failures,
   output int                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      result_type res;
      logic       last;
   } gesture_action_type;

   // Register copies.
   logic [7:0]  two_key, three_key, four_key, five_key, hold_mod_key, move_tol;
   logic [15:0] hold_limit_ms;

   // Pointer table, button owners and hold timer.
   logic [15:0]        slot_owner [SLOTS];
   logic [15:0]        left_id, right_id;
   logic               hold_on;
   logic [31:0]        hold_t0;
   logic signed [15:0] hold_px, hold_py;

   gesture_action_type staged_actions [MAX_RESULTS];
   int                 staged;
   gesture_action_type expected_actions [$];

   task automatic stage_action(input logic [2:0] act, input logic [7:0] key,
                               input logic signed [15:0] x, input logic signed [15:0] y);
      staged_actions[staged].res.action   = act;
      staged_actions[staged].res.key_code = key;
      staged_actions[staged].res.out_x    = x;
      staged_actions[staged].res.out_y    = y;
      staged_actions[staged].last         = 1'b0;
      staged++;
   endtask

   task automatic predict_gesture_actions(input logic [1:0] op, input logic [15:0] id,
                                          input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic stylus, input logic primary,
                                          input logic [31:0] now, input logic susp);
      int          count;
      bit          found;
      logic [31:0] held;
      int          dx, dy;
      staged = 0;
      found  = 1'b0;
      case (op)
         OP_DOWN: begin
            if (!susp) begin
               // The finger count is the position of the first free slot,
               // or the table size when every slot is taken.
               count = 0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!found) begin
                     count++;
                     if (slot_owner[i] == 16'd0) begin
                        slot_owner[i] = id;
                        found = 1'b1;
                     end
                  end
               end
               if (stylus) count = 2;
               case (count)
                  1: begin
                     stage_action(ACT_LEFT_DOWN, KEY_NONE, x, y);
                     left_id = id;
                     if (hold_mod_key != KEY_NONE) begin
                        hold_on = 1'b1;
                        hold_t0 = now;
                        hold_px = x;
                        hold_py = y;
                     end
                  end
                  2: begin
                     if (two_key == KEY_RIGHT_BUTTON) begin
                        stage_action(ACT_RIGHT_DOWN, KEY_NONE, 16'sd0, 16'sd0);
                        right_id = id;
                     end else begin
                        stage_action(ACT_KEY_PRESS, two_key, 16'sd0, 16'sd0);
                     end
                  end
                  3: begin
                     if (three_key != KEY_NONE)
                        stage_action(ACT_KEY_PRESS, three_key, 16'sd0, 16'sd0);
                  end
                  4: begin
                     if (four_key != KEY_NONE)
                        stage_action(ACT_KEY_PRESS, four_key, 16'sd0, 16'sd0);
                  end
                  5: begin
                     if (five_key == KEY_CALIBRATE)
                        stage_action(ACT_CALIBRATE, KEY_NONE, 16'sd0, 16'sd0);
                     else if (five_key != KEY_NONE)
                        stage_action(ACT_KEY_PRESS, five_key, 16'sd0, 16'sd0);
                  end
                  default: ;
               endcase
            end
         end
         OP_UP: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && slot_owner[i] == id) begin
                  slot_owner[i] = 16'd0;
                  found = 1'b1;
               end
            end
            if (left_id != 16'd0 && left_id == id) begin
               stage_action(ACT_LEFT_UP, KEY_NONE, 16'sd0, 16'sd0);
               left_id = 16'd0;
               held = now - hold_t0;
               if (hold_on && held > {16'd0, hold_limit_ms})
                  stage_action(ACT_HOLD_CLICK, hold_mod_key, 16'sd0, 16'sd0);
               hold_on = 1'b0;
            end
            if (right_id != 16'd0 && right_id == id) begin
               stage_action(ACT_RIGHT_UP, KEY_NONE, 16'sd0, 16'sd0);
               right_id = 16'd0;
            end
         end
         OP_UPDATE: begin
            if (!susp) begin
               if (primary) stage_action(ACT_MOVE, KEY_NONE, x, y);
               dx = int'(x) - int'(hold_px);
               dy = int'(y) - int'(hold_py);
               if (dx < 0) dx = -dx;
               if (dy < 0) dy = -dy;
               // Moving the held finger too far restarts the hold timer.
               if (left_id != 16'd0 && id == left_id && hold_on &&
                   (dx > int'(move_tol) || dy > int'(move_tol))) begin
                  hold_t0 = now;
                  hold_px = x;
                  hold_py = y;
               end
            end
         end
         default: ;
      endcase
      if (staged > 0) staged_actions[staged-1].last = 1'b1;
      for (int i = 0; i < staged; i++) expected_actions.push_back(staged_actions[i]);
   endtask

   always @(posedge clock) begin
      gesture_action_type want;
      if (reset) begin
         two_key       = RST_TWO_FINGER_KEY;
         three_key     = RST_THREE_FINGER_KEY;
         four_key      = RST_FOUR_FINGER_KEY;
         five_key      = RST_FIVE_FINGER_KEY;
         hold_mod_key  = RST_HOLD_KEY;
         hold_limit_ms = RST_HOLD_TIME_MS;
         move_tol      = RST_MOVE_LIMIT;
         for (int i = 0; i < SLOTS; i++) slot_owner[i] = 16'd0;
         left_id  = 16'd0;
         right_id = 16'd0;
         hold_on  = 1'b0;
         hold_t0  = 32'd0;
         hold_px  = 16'sd0;
         hold_py  = 16'sd0;
         expected_actions.delete();
         failures = 0;
      end else begin
         // Results always belong to events accepted at earlier edges.
         if (rsp_valid && !rsp_stall) begin
            if (expected_actions.size() == 0) begin
               $error("result transfer with no prediction waiting: action %0d", rsp_action);
               failures++;
            end else begin
               want = expected_actions.pop_front();
               if (rsp_action !== want.res.action) begin
                  $error("action: expected %0d, actual %0d", want.res.action, rsp_action);
                  failures++;
               end
               if (rsp_key_code !== want.res.key_code) begin
                  $error("key_code: expected %0d, actual %0d", want.res.key_code,
                         rsp_key_code);
                  failures++;
               end
               if (rsp_out_x !== want.res.out_x) begin
                  $error("out_x: expected %0d, actual %0d", want.res.out_x, rsp_out_x);
                  failures++;
               end
               if (rsp_out_y !== want.res.out_y) begin
                  $error("out_y: expected %0d, actual %0d", want.res.out_y, rsp_out_y);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TWO_FINGER_KEY:   two_key       = csr_data[7:0];
               REG_THREE_FINGER_KEY: three_key     = csr_data[7:0];
               REG_FOUR_FINGER_KEY:  four_key      = csr_data[7:0];
               REG_FIVE_FINGER_KEY:  five_key      = csr_data[7:0];
               REG_HOLD_KEY:         hold_mod_key  = csr_data[7:0];
               REG_HOLD_TIME_MS:     hold_limit_ms = csr_data;
               REG_MOVE_LIMIT:       move_tol      = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_gesture_actions(req_operation, req_pointer_id, req_pos_x, req_pos_y,
                                    req_stylus_button, req_primary, req_time_ms,
                                    req_suspended);
      end
      outstanding = expected_actions.size();
   end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives pointer events and register writes into the touch gesture recognizer:
// a directed opening, then random gestures under four idling phases and
// register settings, with a long result hold-off and a full pause.
// ----------------------------------------------------------------------------
module testbench
   import tgr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_RESERVED      = 2'd3;
   localparam int         ITEMS_PER_PHASE  = 100;
   localparam int         LONG_HOLD_CYCLES = 300;
   localparam int         DRAIN_LIMIT      = 20000;
   localparam int         SETTLE_CYCLES    = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_operation = OP_DOWN;
   logic [15:0]            req_pointer_id = 16'd0;
   logic signed [15:0]     req_pos_x = 16'sd0;
   logic signed [15:0]     req_pos_y = 16'sd0;
   logic                   req_stylus_button = 1'b0;
   logic                   req_primary = 1'b0;
   logic [31:0]            req_time_ms = 32'd0;
   logic                   req_suspended = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_action;
   logic [7:0]             rsp_key_code;
   logic signed [15:0]     rsp_out_x;
   logic signed [15:0]     rsp_out_y;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_TWO_FINGER_KEY;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int          failures;
   int          outstanding;
   int          send_gap_pct = 0;
   int          stall_pct = 0;
   int          long_hold_requests = 0;
   int          events_sent = 0;
   logic [31:0] now_ms = 32'd0;
   logic [15:0] hold_setting = RST_HOLD_TIME_MS;
   logic [7:0]  move_setting = RST_MOVE_LIMIT;
   logic [15:0] stray_ids [$];

   touch_gesture_recognizer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_pointer_id    (req_pointer_id),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_stylus_button (req_stylus_button),
      .req_primary       (req_primary),
      .req_time_ms       (req_time_ms),
      .req_suspended     (req_suspended),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_key_code      (rsp_key_code),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   touch_gesture_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_pointer_id    (req_pointer_id),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_stylus_button (req_stylus_button),
      .req_primary       (req_primary),
      .req_time_ms       (req_time_ms),
      .req_suspended     (req_suspended),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_key_code      (rsp_key_code),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Result side: random stalls, and a long hold-off whenever one is requested.
   initial begin
      int hold_left;
      int served;
      hold_left = 0;
      served    = 0;
      forever begin
         @(negedge clock);
         if (served < long_hold_requests) begin
            served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_event(input logic [1:0] op, input logic [15:0] id,
                             input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic stylus, input logic prim, input logic susp);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_gap_pct) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_pointer_id    <= id;
      req_pos_x         <= x;
      req_pos_y         <= y;
      req_stylus_button <= stylus;
      req_primary       <= prim;
      req_time_ms       <= now_ms;
      req_suspended     <= susp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      events_sent++;
   endtask

   // Events without results may still be in flight, hence the settle cycles.
   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] two, input logic [7:0] three,
                                 input logic [7:0] four, input logic [7:0] five,
                                 input logic [7:0] hold_key, input logic [15:0] hold_ms,
                                 input logic [7:0] move_lim);
      logic [CSR_INDEX_W-1:0] idx [7];
      logic [CSR_DATA_W-1:0]  val [7];
      idx[0] = REG_TWO_FINGER_KEY;   val[0] = {8'd0, two};
      idx[1] = REG_THREE_FINGER_KEY; val[1] = {8'd0, three};
      idx[2] = REG_FOUR_FINGER_KEY;  val[2] = {8'd0, four};
      idx[3] = REG_FIVE_FINGER_KEY;  val[3] = {8'd0, five};
      idx[4] = REG_HOLD_KEY;         val[4] = {8'd0, hold_key};
      idx[5] = REG_HOLD_TIME_MS;     val[5] = hold_ms;
      idx[6] = REG_MOVE_LIMIT;       val[6] = {8'd0, move_lim};
      drain_results();
      for (int r = 0; r < 7; r++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[r];
         csr_data  <= val[r];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      hold_setting = hold_ms;
      move_setting = move_lim;
   endtask

   // Time between events: mostly around the hold time, sometimes right on its
   // edge, now and then a jump anywhere in the timestamp range.
   function automatic logic [31:0] hold_gap_ms();
      case ($urandom_range(9))
         0: return $urandom;
         1: return {16'd0, hold_setting} + $urandom_range(0, 1);
         default: return $urandom_range(0, 2 * hold_setting + 2);
      endcase
   endfunction

   initial begin
      int          phase_end;
      int          fingers;
      int          first;
      int          pick;
      int          dx;
      int          dy;
      bit          paused;
      logic [1:0]  stray_op;
      logic [15:0] stray_id;
      logic        stray_susp;
      logic [15:0]        finger_id [6];
      logic signed [15:0] finger_x [6];
      logic signed [15:0] finger_y [6];

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening under the reset settings.
      now_ms = 32'd1000;
      send_event(OP_DOWN, 16'd1, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 1'b0);
      now_ms = 32'd1200;
      send_event(OP_UPDATE, 16'd1, 16'sh8002, 16'sh7FFF, 1'b0, 1'b1, 1'b0);
      now_ms = 32'd1300;
      // Moves five pixels from the touch point, so the hold timer restarts.
      send_event(OP_UPDATE, 16'd1, 16'sh8005, 16'sh7FFF, 1'b0, 1'b0, 1'b0);
      send_event(OP_DOWN, 16'd2, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1, 1'b0);
      send_event(OP_DOWN, 16'd3, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_DOWN, 16'd4, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_DOWN, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      // The table is full now.
      send_event(OP_DOWN, 16'd9, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_DOWN, 16'd8, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0);
      send_event(OP_UP, 16'd2, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_UP, 16'd8, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_DOWN, 16'd10, 16'sd5, 16'sd5, 1'b0, 1'b0, 1'b1);
      send_event(OP_UPDATE, 16'd1, 16'sd5, 16'sd5, 1'b0, 1'b1, 1'b1);
      send_event(OP_RESERVED, 16'd1, 16'sd5, 16'sd5, 1'b1, 1'b1, 1'b0);
      // Held exactly the hold time: no click. Suspension does not stop an up.
      now_ms = 32'd1800;
      send_event(OP_UP, 16'd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1);
      send_event(OP_DOWN, 16'd0, 16'sd7, 16'sd9, 1'b0, 1'b0, 1'b0);
      send_event(OP_UP, 16'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      // One pointer owning both buttons, released across the timestamp wrap.
      now_ms = 32'hFFFF_FF00;
      send_event(OP_DOWN, 16'd5, 16'sd100, 16'sd200, 1'b0, 1'b0, 1'b0);
      send_event(OP_DOWN, 16'd5, 16'sd100, 16'sd200, 1'b1, 1'b0, 1'b0);
      now_ms = 32'h0000_0100;
      send_event(OP_UP, 16'd5, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_UP, 16'd5, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_UP, 16'd3, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_UP, 16'd4, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_UP, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
      send_event(OP_UP, 16'd9, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 0;
               stall_pct    = 0;
               apply_settings(8'd0, 8'd255, 8'd1, KEY_CALIBRATE, 8'd255, 16'd0, 8'd0);
            end
            1: begin
               send_gap_pct = 83;
               stall_pct    = 0;
               apply_settings(8'd255, KEY_NONE, 8'd255, 8'd255, 8'd1, 16'hFFFF, 8'd255);
            end
            2: begin
               send_gap_pct = 0;
               stall_pct    = 83;
               apply_settings(KEY_RIGHT_BUTTON, 8'd27, 8'd200, KEY_NONE, 8'd18, 16'd500,
                              8'd4);
            end
            default: begin
               send_gap_pct = 27;
               stall_pct    = 27;
               apply_settings($urandom_range(1) ? KEY_RIGHT_BUTTON : 8'($urandom),
                              8'($urandom), 8'($urandom),
                              $urandom_range(1) ? KEY_CALIBRATE : 8'($urandom),
                              ($urandom_range(3) == 0) ? KEY_NONE : 8'($urandom),
                              16'($urandom_range(0, 1000)), 8'($urandom_range(0, 20)));
            end
         endcase
         paused    = 1'b0;
         phase_end = events_sent + ITEMS_PER_PHASE;
         while (events_sent < phase_end) begin
            if (phase == 0 && long_hold_requests == 0 && events_sent > phase_end - 70)
               long_hold_requests++;
            if (phase == 2 && !paused && events_sent > phase_end - 50) begin
               paused = 1'b1;
               drain_results();
            end
            if ($urandom_range(9) == 0) begin
               stray_op   = 2'($urandom_range(3));
               stray_id   = 16'($urandom);
               stray_susp = ($urandom_range(3) == 0);
               send_event(stray_op, stray_id, 16'($urandom), 16'($urandom),
                          1'($urandom_range(1)), 1'($urandom_range(1)), stray_susp);
               if (stray_op == OP_DOWN && !stray_susp) stray_ids.push_back(stray_id);
            end else begin
               fingers = $urandom_range(1, 6);
               for (int f = 0; f < fingers; f++) begin
                  finger_id[f] = ($urandom_range(3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 12));
                  finger_x[f]  = 16'($urandom);
                  finger_y[f]  = 16'($urandom);
                  send_event(OP_DOWN, finger_id[f], finger_x[f], finger_y[f],
                             ($urandom_range(9) == 0), 1'($urandom_range(1)),
                             ($urandom_range(19) == 0));
                  now_ms += $urandom_range(0, 40);
               end
               repeat ($urandom_range(0, 4)) begin
                  pick = $urandom_range(0, fingers - 1);
                  // Jitter around the touch point, on both sides of the limit.
                  dx = int'($urandom_range(0, 2 * move_setting + 2)) - (move_setting + 1);
                  dy = int'($urandom_range(0, 2 * move_setting + 2)) - (move_setting + 1);
                  if ($urandom_range(4) == 0) dx = $urandom;
                  send_event(OP_UPDATE, finger_id[pick], finger_x[pick] + 16'(dx),
                             finger_y[pick] + 16'(dy), 1'($urandom_range(1)),
                             1'($urandom_range(1)), ($urandom_range(19) == 0));
                  now_ms += hold_gap_ms();
               end
               now_ms += hold_gap_ms();
               first = $urandom_range(0, fingers - 1);
               for (int f = 0; f < fingers; f++) begin
                  send_event(OP_UP, finger_id[(first + f) % fingers], 16'($urandom),
                             16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                             ($urandom_range(9) == 0));
                  now_ms += $urandom_range(0, 40);
               end
               if (stray_ids.size() > 0 && $urandom_range(1))
                  send_event(OP_UP, stray_ids.pop_front(), 16'sd0, 16'sd0, 1'b0, 1'b0,
                             1'b0);
            end
         end
      end

      drain_results();
      if (outstanding != 0)
         $error("%0d predicted results never arrived", outstanding);
      if (failures == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
